FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the drive controller RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock, off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/dcmc_pkg.sv
// ----------------------------------------------------------------------------
// dcmc_pkg
// Types, codes and limits shared by the drive command and mode controller.
// ----------------------------------------------------------------------------
package dcmc_pkg;

    // Field widths
    localparam int CMD_W   = 8;
    localparam int DIST_W  = 10;
    localparam int DUTY_W  = 10;
    localparam int CFG_W   = 10;
    localparam int PINS_W  = 4;
    localparam int MODE_W  = 2;
    localparam int DEC_W   = 3;
    localparam int CFG_IDX_W = 3;

    // Saturation limits
    localparam logic [DUTY_W-1:0] DUTY_MAX = 10'd1000;
    localparam logic [DIST_W-1:0] DIST_MAX = 10'd1023;

    // Reset value of the speed setting
    localparam logic [DUTY_W-1:0] SPEED_RESET = 10'd430;

    // Word kinds
    localparam logic OP_COMMAND = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Command bytes
    localparam logic [CMD_W-1:0] CMD_PAUSE  = 8'h50;  // P
    localparam logic [CMD_W-1:0] CMD_START  = 8'h41;  // A
    localparam logic [CMD_W-1:0] CMD_MANUAL = 8'h53;  // S
    localparam logic [CMD_W-1:0] CMD_SELF   = 8'h43;  // C
    localparam logic [CMD_W-1:0] CMD_FASTER = 8'h54;  // T
    localparam logic [CMD_W-1:0] CMD_SLOWER = 8'h58;  // X
    localparam logic [CMD_W-1:0] CMD_FWD    = 8'h46;  // F
    localparam logic [CMD_W-1:0] CMD_REV    = 8'h42;  // B
    localparam logic [CMD_W-1:0] CMD_LEFT   = 8'h4C;  // L
    localparam logic [CMD_W-1:0] CMD_RIGHT  = 8'h52;  // R

    // Drive modes
    localparam logic [MODE_W-1:0] MODE_STOP   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SELF   = 2'd2;

    // H-bridge patterns
    localparam logic [PINS_W-1:0] PINS_FWD   = 4'h5;
    localparam logic [PINS_W-1:0] PINS_REV   = 4'hA;
    localparam logic [PINS_W-1:0] PINS_RIGHT = 4'h9;
    localparam logic [PINS_W-1:0] PINS_LEFT  = 4'h6;

    // Self-driving decisions
    localparam logic [DEC_W-1:0] DEC_NONE    = 3'd0;
    localparam logic [DEC_W-1:0] DEC_FORWARD = 3'd1;
    localparam logic [DEC_W-1:0] DEC_RIGHT   = 3'd2;
    localparam logic [DEC_W-1:0] DEC_LEFT    = 3'd3;
    localparam logic [DEC_W-1:0] DEC_REVERSE = 3'd4;
    localparam logic [DEC_W-1:0] DEC_BRAKE   = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_STEP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_REDUCTION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_DUTY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_DIST     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_DIST      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REAR_CLEAR     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_OFFSET    = 3'd6;

    // Configuration reset values
    localparam logic [CFG_W-1:0] RST_SPEED_STEP     = 10'd10;
    localparam logic [CFG_W-1:0] RST_TURN_REDUCTION = 10'd50;
    localparam logic [CFG_W-1:0] RST_REVERSE_DUTY   = 10'd400;
    localparam logic [CFG_W-1:0] RST_CLEAR_DIST     = 10'd60;
    localparam logic [CFG_W-1:0] RST_SIDE_DIST      = 10'd40;
    localparam logic [CFG_W-1:0] RST_REAR_CLEAR     = 10'd50;
    localparam logic [CFG_W-1:0] RST_LEFT_OFFSET    = 10'd3;

    // Thresholds handed to the obstacle avoider
    typedef struct packed {
        logic [CFG_W-1:0] clear_dist;
        logic [CFG_W-1:0] side_dist;
        logic [CFG_W-1:0] rear_clear;
        logic [CFG_W-1:0] left_offset;
    } t_avoid_cfg;

    // Clamp a distance to the sensor range
    function automatic logic [DIST_W-1:0] lim_dist(input logic [DIST_W-1:0] v);
        return (v > DIST_MAX) ? DIST_MAX : v;
    endfunction

endpackage

FILE: hw/rtl/dcmc_in_if.sv
// ----------------------------------------------------------------------------
// dcmc_in_if
// Input channel: a command byte or a sensor tick with three distances.
// ----------------------------------------------------------------------------
interface dcmc_in_if
    import dcmc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              operation;
    logic [CMD_W-1:0]  command_byte;
    logic [DIST_W-1:0] left_distance;
    logic [DIST_W-1:0] right_distance;
    logic [DIST_W-1:0] rear_distance;

    modport source (
        output valid, operation, command_byte, left_distance, right_distance,
               rear_distance,
        input  ready
    );

    modport sink (
        input  valid, operation, command_byte, left_distance, right_distance,
               rear_distance,
        output ready
    );
endinterface

FILE: hw/rtl/dcmc_out_if.sv
// ----------------------------------------------------------------------------
// dcmc_out_if
// Result channel: drive outputs and status after each input word.
// ----------------------------------------------------------------------------
interface dcmc_out_if
    import dcmc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [PINS_W-1:0] bridge_pins;
    logic [DUTY_W-1:0] duty;
    logic [MODE_W-1:0] drive_mode;
    logic              running;
    logic [DEC_W-1:0]  decision;
    logic              acknowledge;

    modport source (
        output valid, bridge_pins, duty, drive_mode, running, decision, acknowledge,
        input  ready
    );

    modport sink (
        input  valid, bridge_pins, duty, drive_mode, running, decision, acknowledge,
        output ready
    );
endinterface

FILE: hw/rtl/dcmc_avoid.sv
// ----------------------------------------------------------------------------
// dcmc_avoid
// Obstacle avoider: picks forward, right, left, reverse or brake from the
// three ultrasonic distances and the configured thresholds.
// ----------------------------------------------------------------------------
module dcmc_avoid
    import dcmc_pkg::*;
(
    input  logic [DIST_W-1:0] i_left_raw,
    input  logic [DIST_W-1:0] i_right,
    input  logic [DIST_W-1:0] i_rear,
    input  t_avoid_cfg        i_cfg,
    output logic [DEC_W-1:0]  o_decision
);

    logic [DIST_W-1:0] left_lim;
    logic [DIST_W-1:0] left_d;
    logic [DIST_W-1:0] right_d;
    logic [DIST_W-1:0] rear_d;

    // Clamp, then remove the left sensor offset (floor at zero)
    assign left_lim = lim_dist(i_left_raw);
    assign left_d   = (left_lim > i_cfg.left_offset) ? (left_lim - i_cfg.left_offset)
                                                     : '0;
    assign right_d  = lim_dist(i_right);
    assign rear_d   = lim_dist(i_rear);

    // Priority: open road, then the wider side, then back out, else brake
    always_comb begin
        if (left_d >= i_cfg.clear_dist && right_d >= i_cfg.clear_dist) begin
            o_decision = DEC_FORWARD;
        end else if (right_d >= left_d && right_d > i_cfg.side_dist) begin
            o_decision = DEC_RIGHT;
        end else if (left_d > right_d && left_d > i_cfg.side_dist) begin
            o_decision = DEC_LEFT;
        end else if (rear_d >= i_cfg.rear_clear) begin
            o_decision = DEC_REVERSE;
        end else begin
            o_decision = DEC_BRAKE;
        end
    end

endmodule

FILE: hw/rtl/drive_command_mode_controller_top.sv
// ----------------------------------------------------------------------------
// drive_command_mode_controller_top
// Command and mode controller for a two-motor car: run flag, drive mode,
// speed setting, H-bridge pins and PWM duty.
// ----------------------------------------------------------------------------
// Usage: each accepted word (command byte or sensor tick) yields exactly one
// result word. The block accepts one word per clock while the sink does not
// stall; a result is offered once its word has passed the input register and
// then the result register. The single compute stage reads the controller
// state and writes it back in the same cycle, so consecutive words chain with
// no bubble. The result register holds a word while the sink stalls; the
// input register keeps taking a word during that stall until it is full.
// Configuration writes take effect at the next edge and are meant for idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module drive_command_mode_controller_top
    import dcmc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    dcmc_in_if.sink              i_item,
    dcmc_out_if.source           o_result
);

    // Configuration registers
    logic [CFG_W-1:0] r_speed_step;
    logic [CFG_W-1:0] r_turn_red;
    logic [CFG_W-1:0] r_rev_duty;
    logic [CFG_W-1:0] r_clear_dist;
    logic [CFG_W-1:0] r_side_dist;
    logic [CFG_W-1:0] r_rear_clear;
    logic [CFG_W-1:0] r_left_offset;

    // Input register
    logic              r_in_valid;
    logic              r_in_op;
    logic [CMD_W-1:0]  r_in_cmd;
    logic [DIST_W-1:0] r_in_left;
    logic [DIST_W-1:0] r_in_right;
    logic [DIST_W-1:0] r_in_rear;

    // Controller state
    logic              r_run;
    logic [MODE_W-1:0] r_mode;
    logic [DUTY_W-1:0] r_speed;
    logic [DUTY_W-1:0] r_duty;
    logic [PINS_W-1:0] r_pins;

    logic              n_run;
    logic [MODE_W-1:0] n_mode;
    logic [DUTY_W-1:0] n_speed;
    logic [DUTY_W-1:0] n_duty;
    logic [PINS_W-1:0] n_pins;
    logic [DEC_W-1:0]  n_dec;
    logic              n_ack;

    // Result register
    logic              r_out_valid;
    logic [DEC_W-1:0]  r_out_dec;
    logic              r_out_ack;

    logic              in_take;
    logic              advance;
    logic [DUTY_W:0]   speed_sum;
    logic [DUTY_W-1:0] speed_up;
    logic [DUTY_W-1:0] speed_down;
    logic [DUTY_W-1:0] turn_duty;
    logic [DUTY_W-1:0] rev_duty;
    logic [DEC_W-1:0]  avoid_dec;
    t_avoid_cfg        avoid_cfg;

    // Handshake: stage moves when the result register is free or draining
    assign advance        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready   = !r_in_valid || advance;
    assign in_take        = i_item.valid && i_item.ready;

    // Configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_step  <= RST_SPEED_STEP;
            r_turn_red    <= RST_TURN_REDUCTION;
            r_rev_duty    <= RST_REVERSE_DUTY;
            r_clear_dist  <= RST_CLEAR_DIST;
            r_side_dist   <= RST_SIDE_DIST;
            r_rear_clear  <= RST_REAR_CLEAR;
            r_left_offset <= RST_LEFT_OFFSET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SPEED_STEP:     r_speed_step  <= i_cfg_data;
                CFG_TURN_REDUCTION: r_turn_red    <= i_cfg_data;
                CFG_REVERSE_DUTY:   r_rev_duty    <= i_cfg_data;
                CFG_CLEAR_DIST:     r_clear_dist  <= i_cfg_data;
                CFG_SIDE_DIST:      r_side_dist   <= i_cfg_data;
                CFG_REAR_CLEAR:     r_rear_clear  <= i_cfg_data;
                CFG_LEFT_OFFSET:    r_left_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op    <= i_item.operation;
            r_in_cmd   <= i_item.command_byte;
            r_in_left  <= i_item.left_distance;
            r_in_right <= i_item.right_distance;
            r_in_rear  <= i_item.rear_distance;
        end
    end

    // Obstacle avoider
    assign avoid_cfg.clear_dist  = r_clear_dist;
    assign avoid_cfg.side_dist   = r_side_dist;
    assign avoid_cfg.rear_clear  = r_rear_clear;
    assign avoid_cfg.left_offset = r_left_offset;

    dcmc_avoid u_avoid (
        .i_left_raw (r_in_left),
        .i_right    (r_in_right),
        .i_rear     (r_in_rear),
        .i_cfg      (avoid_cfg),
        .o_decision (avoid_dec)
    );

    // Speed and duty arithmetic, all saturating
    assign speed_sum  = {1'b0, r_speed} + {1'b0, r_speed_step};
    assign speed_up   = (speed_sum > {1'b0, DUTY_MAX}) ? DUTY_MAX : speed_sum[DUTY_W-1:0];
    assign speed_down = (r_speed > r_speed_step) ? (r_speed - r_speed_step) : '0;
    assign turn_duty  = (r_speed > r_turn_red) ? (r_speed - r_turn_red) : '0;
    assign rev_duty   = (r_rev_duty > DUTY_MAX) ? DUTY_MAX : r_rev_duty;

    // Next state for the word in the input register
    always_comb begin
        n_run   = r_run;
        n_mode  = r_mode;
        n_speed = r_speed;
        n_duty  = r_duty;
        n_pins  = r_pins;
        n_dec   = DEC_NONE;
        n_ack   = 1'b0;

        if (r_in_op == OP_COMMAND) begin
            n_ack = 1'b1;

            // pause / start
            unique case (r_in_cmd)
                CMD_PAUSE: begin
                    n_run  = 1'b0;
                    n_mode = MODE_STOP;
                    n_duty = '0;
                end
                CMD_START: begin
                    n_run  = 1'b1;
                    n_mode = MODE_STOP;
                    n_duty = '0;
                end
                default: ;
            endcase

            // mode select and speed change, only while running
            if (n_run) begin
                unique case (r_in_cmd)
                    CMD_MANUAL: begin
                        n_duty = '0;
                        n_mode = MODE_MANUAL;
                    end
                    CMD_SELF: begin
                        n_duty = '0;
                        n_mode = MODE_SELF;
                    end
                    CMD_FASTER: n_speed = speed_up;
                    CMD_SLOWER: n_speed = speed_down;
                    default: ;
                endcase
            end

            // manual drive
            if (n_mode == MODE_MANUAL) begin
                unique case (r_in_cmd)
                    CMD_FWD: begin
                        n_pins = PINS_FWD;
                        n_duty = r_speed;
                    end
                    CMD_REV: begin
                        n_pins = PINS_REV;
                        n_duty = rev_duty;
                    end
                    CMD_RIGHT: begin
                        n_pins = PINS_RIGHT;
                        n_duty = turn_duty;
                    end
                    CMD_LEFT: begin
                        n_pins = PINS_LEFT;
                        n_duty = turn_duty;
                    end
                    default: ;
                endcase
            end
        end else if (r_mode == MODE_SELF) begin
            // sensor tick in self-driving mode
            n_dec = avoid_dec;
            unique case (avoid_dec)
                DEC_FORWARD: begin
                    n_pins = PINS_FWD;
                    n_duty = r_speed;
                end
                DEC_RIGHT: begin
                    n_pins = PINS_RIGHT;
                    n_duty = turn_duty;
                end
                DEC_LEFT: begin
                    n_pins = PINS_LEFT;
                    n_duty = turn_duty;
                end
                DEC_REVERSE: begin
                    n_pins = PINS_REV;
                    n_duty = r_speed;
                end
                default: n_duty = '0;   // brake keeps the pins
            endcase
        end
    end

    // Controller state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_mode  <= MODE_STOP;
            r_speed <= SPEED_RESET;
            r_duty  <= '0;
            r_pins  <= '0;
        end else if (advance) begin
            r_run   <= n_run;
            r_mode  <= n_mode;
            r_speed <= n_speed;
            r_duty  <= n_duty;
            r_pins  <= n_pins;
        end
    end

    // Result register; state fields are read straight from the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_dec <= n_dec;
            r_out_ack <= n_ack;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.bridge_pins = r_pins;
    assign o_result.duty        = r_duty;
    assign o_result.drive_mode  = r_mode;
    assign o_result.running     = r_run;
    assign o_result.decision    = r_out_dec;
    assign o_result.acknowledge = r_out_ack;

    // Checks
    `ASSERT_IMPL(a_speed_in_range, i_clk, i_rst_n, 1'b1, r_speed <= DUTY_MAX)
    `ASSERT_IMPL(a_stopped_when_paused, i_clk, i_rst_n, !r_run, r_mode == MODE_STOP)
    `ASSERT_IMPL(a_no_duty_when_stopped, i_clk, i_rst_n, r_mode == MODE_STOP, r_duty == '0)
    `ASSERT_IMPL(a_cmd_no_decision, i_clk, i_rst_n, r_out_valid && r_out_ack,
                 r_out_dec == DEC_NONE)
    `ASSERT_NEXT(a_result_held, i_clk, i_rst_n, r_out_valid && !o_result.ready && !advance,
                 r_out_valid && $stable(r_out_dec) && $stable(r_duty))

endmodule
